/* rtl/core/liyuv_pkg.sv */
package liyuv_pkg;

  localparam int ADDR_W = 25;
  localparam int PIX_W  = 8;

  localparam int RESET_WIDTH  = 640;
  localparam int RESET_HEIGHT = 480;
  localparam int RESET_AREA   = RESET_WIDTH * RESET_HEIGHT;
  localparam int RESET_AREA2  = RESET_AREA + RESET_AREA / 4;

  localparam logic [PIX_W-1:0] SIGN_FLIP = 8'h80;

  localparam logic [1:0] CFG_LAYOUT = 2'd0;
  localparam logic [1:0] CFG_SWAP   = 2'd1;
  localparam logic [1:0] CFG_WIDTH  = 2'd2;
  localparam logic [1:0] CFG_HEIGHT = 2'd3;

  localparam logic [1:0] LAYOUT_YUYV = 2'd0;
  localparam logic [1:0] LAYOUT_YYUV = 2'd1;
  localparam logic [1:0] LAYOUT_YUVY = 2'd2;

  localparam logic [1:0] SEG_IDX_LAST = 2'd3;

  typedef enum logic [1:0] {
    SEG_YTOP = 2'd0,
    SEG_YBOT = 2'd1,
    SEG_U    = 2'd2,
    SEG_V    = 2'd3
  } seg_kind_t;

  function automatic seg_kind_t seg_kind(logic [1:0] mode, logic [1:0] idx);
    seg_kind_t k;
    k = SEG_YTOP;
    case (mode)
      LAYOUT_YYUV: begin
        case (idx)
          2'd0:    k = SEG_YTOP;
          2'd1:    k = SEG_YBOT;
          2'd2:    k = SEG_U;
          default: k = SEG_V;
        endcase
      end
      LAYOUT_YUVY: begin
        case (idx)
          2'd0:    k = SEG_YTOP;
          2'd1:    k = SEG_U;
          2'd2:    k = SEG_V;
          default: k = SEG_YBOT;
        endcase
      end
      default: begin
        case (idx)
          2'd0:    k = SEG_YTOP;
          2'd1:    k = SEG_U;
          2'd2:    k = SEG_YBOT;
          default: k = SEG_V;
        endcase
      end
    endcase
    return k;
  endfunction

endpackage

/* rtl/core/line_interleaved_yuv_to_planar_yuv420_core.sv */
// Channel   Direction  Handshake             Payload
// src       in         src_valid/src_stall   src_byte
// dst       out        dst_valid/dst_stall   dest_addr, pixel, frame_last
// cfg       in         cfg_valid/cfg_ready   cfg_index, cfg_data
//
// One byte per clock sustained unless dst stalls; a result appears in the cycle
// after its transfer, from the single result register behind the address adders.
// Reset returns registers to 640x480, layout 0, no swap, frame position zero.
// src stalls only while a result is held and dst stalls; cfg is always ready.
module line_interleaved_yuv_to_planar_yuv420_core
  import liyuv_pkg::*;
#(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    src_valid,
  output logic                    src_stall,
  input  logic [PIX_W-1:0]        src_byte,
  output logic                    dst_valid,
  input  logic                    dst_stall,
  output logic [ADDR_W-1:0]       dest_addr,
  output logic [PIX_W-1:0]        pixel,
  output logic                    frame_last,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [((MAX_WIDTH > MAX_HEIGHT) ? $clog2(MAX_WIDTH + 1)
                 : $clog2(MAX_HEIGHT + 1))-1:0] cfg_data
);

  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int DW = (WW > HW) ? WW : HW;
  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT / 2) : 1;
  localparam int PW = WW + HW;

  logic [1:0]        layout_mode;
  logic              swap_chroma;
  logic [WW-1:0]     frame_width;
  logic [HW-1:0]     frame_height;
  logic [ADDR_W-1:0] area;
  logic [ADDR_W-1:0] area2;

  logic [1:0]        segment_index;
  logic [CW-1:0]     column_count;
  logic [RW-1:0]     row_pair_count;
  logic [ADDR_W-1:0] y_base;
  logic [ADDR_W-1:0] c_base;

  logic              src_take;
  logic              cfg_take;
  logic              cfg_ok;
  logic [WW-1:0]     mul_w;
  logic [HW-1:0]     mul_h;
  logic [PW-1:0]     prod;

  seg_kind_t         kind;
  logic              is_y;
  logic              first_plane;
  logic [WW-1:0]     col_lim;
  logic              seg_end;
  logic              rp_end;
  logic              last;
  logic [ADDR_W-1:0] col_ext;
  logic [ADDR_W-1:0] addr_next;

  assign cfg_ready = 1'b1;
  assign cfg_take  = cfg_valid & cfg_ready;
  assign src_stall = dst_valid & dst_stall;
  assign src_take  = src_valid & ~src_stall;

  always_comb begin
    cfg_ok = 1'b0;
    case (cfg_index)
      CFG_LAYOUT: cfg_ok = (cfg_data <= DW'(LAYOUT_YUVY));
      CFG_SWAP:   cfg_ok = 1'b1;
      CFG_WIDTH:  cfg_ok = (cfg_data >= DW'(16)) && (cfg_data <= DW'(MAX_WIDTH))
                           && (cfg_data[3:0] == 4'd0);
      CFG_HEIGHT: cfg_ok = (cfg_data >= DW'(2)) && (cfg_data <= DW'(MAX_HEIGHT))
                           && !cfg_data[0];
      default:    cfg_ok = 1'b0;
    endcase
  end

  assign mul_w = (cfg_index == CFG_WIDTH)  ? cfg_data[WW-1:0] : frame_width;
  assign mul_h = (cfg_index == CFG_HEIGHT) ? cfg_data[HW-1:0] : frame_height;
  assign prod  = PW'(mul_w) * PW'(mul_h);

  always_ff @(posedge clk) begin
    if (rst) begin
      layout_mode  <= LAYOUT_YUYV;
      swap_chroma  <= 1'b0;
      frame_width  <= WW'(RESET_WIDTH);
      frame_height <= HW'(RESET_HEIGHT);
      area         <= ADDR_W'(RESET_AREA);
      area2        <= ADDR_W'(RESET_AREA2);
    end else if (cfg_take && cfg_ok) begin
      case (cfg_index)
        CFG_LAYOUT: layout_mode  <= cfg_data[1:0];
        CFG_SWAP:   swap_chroma  <= cfg_data[0];
        CFG_WIDTH:  frame_width  <= cfg_data[WW-1:0];
        CFG_HEIGHT: frame_height <= cfg_data[HW-1:0];
        default:    layout_mode  <= layout_mode;
      endcase
      area  <= ADDR_W'(prod);
      area2 <= ADDR_W'(prod + (prod >> 2));
    end
  end

  assign kind        = seg_kind(layout_mode, segment_index);
  assign is_y        = (kind == SEG_YTOP) || (kind == SEG_YBOT);
  assign first_plane = (kind == SEG_U) ^ swap_chroma;
  assign col_lim     = is_y ? (frame_width - WW'(1)) : ((frame_width >> 1) - WW'(1));
  assign seg_end     = (WW'(column_count) == col_lim);
  assign rp_end      = (HW'(row_pair_count) == ((frame_height >> 1) - HW'(1)));
  assign last        = seg_end && (segment_index == SEG_IDX_LAST) && rp_end;
  assign col_ext     = ADDR_W'(column_count);

  always_comb begin
    if (is_y) begin
      addr_next = y_base + col_ext
                  + ((kind == SEG_YBOT) ? ADDR_W'(frame_width) : '0);
    end else begin
      addr_next = (first_plane ? area : area2) + c_base + col_ext;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (cfg_take && cfg_ok)) begin
      segment_index  <= '0;
      column_count   <= '0;
      row_pair_count <= '0;
      y_base         <= '0;
      c_base         <= '0;
    end else if (src_take) begin
      if (last) begin
        segment_index  <= '0;
        column_count   <= '0;
        row_pair_count <= '0;
        y_base         <= '0;
        c_base         <= '0;
      end else if (seg_end) begin
        column_count <= '0;
        if (segment_index == SEG_IDX_LAST) begin
          segment_index  <= '0;
          row_pair_count <= row_pair_count + RW'(1);
          y_base         <= y_base + ADDR_W'({frame_width, 1'b0});
          c_base         <= c_base + ADDR_W'(frame_width >> 1);
        end else begin
          segment_index <= segment_index + 2'd1;
        end
      end else begin
        column_count <= column_count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dst_valid <= 1'b0;
    end else begin
      dst_valid <= src_take | (dst_valid & dst_stall);
    end
  end

  always_ff @(posedge clk) begin
    if (src_take) begin
      dest_addr  <= addr_next;
      pixel      <= src_byte ^ SIGN_FLIP;
      frame_last <= last;
    end
  end

endmodule

/* tb/tb_line_interleaved_yuv_to_planar_yuv420_core.sv */
import liyuv_pkg::*;

localparam int LIM_WIDTH  = 4096;
localparam int LIM_HEIGHT = 4096;
localparam int CFG_W      = 13;

typedef struct packed {
  logic [ADDR_W-1:0] addr;
  logic [PIX_W-1:0]  pix;
  logic              last;
} dest_word_t;

class i420_addr_tracker;
  logic [1:0]  layout;
  bit          swap;
  int unsigned width;
  int unsigned height;
  logic [1:0]  seg_idx;
  int unsigned col;
  int unsigned row_pair;
  seg_kind_t   seg_order [0:2][0:3];
  dest_word_t  pending_dests [$];
  int          errors;
  int          bytes_checked;
  int          frames_done;
  int          writes_taken;
  int          writes_refused;

  function new();
    seg_order[0] = '{SEG_YTOP, SEG_U, SEG_YBOT, SEG_V};
    seg_order[1] = '{SEG_YTOP, SEG_YBOT, SEG_U, SEG_V};
    seg_order[2] = '{SEG_YTOP, SEG_U, SEG_V, SEG_YBOT};
    layout = LAYOUT_YUYV;
    swap = 1'b0;
    width = RESET_WIDTH;
    height = RESET_HEIGHT;
    seg_idx = '0;
    col = 0;
    row_pair = 0;
    errors = 0;
    bytes_checked = 0;
    frames_done = 0;
    writes_taken = 0;
    writes_refused = 0;
  endfunction

  function void apply_write(logic [1:0] idx, logic [CFG_W-1:0] data);
    case (idx)
      CFG_LAYOUT: begin
        if (data > 2) begin
          writes_refused++;
          return;
        end
        layout = data[1:0];
      end
      CFG_SWAP: swap = data[0];
      CFG_WIDTH: begin
        if (data < 16 || data > LIM_WIDTH || data[3:0] != 4'd0) begin
          writes_refused++;
          return;
        end
        width = 32'(data);
      end
      default: begin
        if (data < 2 || data > LIM_HEIGHT || data[0]) begin
          writes_refused++;
          return;
        end
        height = 32'(data);
      end
    endcase
    writes_taken++;
    seg_idx = '0;
    col = 0;
    row_pair = 0;
  endfunction

  function void note_byte(logic [PIX_W-1:0] b);
    seg_kind_t       kind;
    longint unsigned w;
    longint unsigned area;
    longint unsigned seg_len;
    longint unsigned addr;
    bit              first_plane;
    bit              seg_end;
    bit              last;
    dest_word_t      e;
    w = width;
    area = w * height;
    kind = seg_order[layout][seg_idx];
    if (kind == SEG_YTOP || kind == SEG_YBOT) begin
      seg_len = w;
      addr = (2 * longint'(row_pair) + ((kind == SEG_YBOT) ? 1 : 0)) * w + col;
    end else begin
      seg_len = w / 2;
      first_plane = (kind == SEG_U) != swap;
      addr = (first_plane ? area : (area * 5) / 4) + longint'(row_pair) * (w / 2) + col;
    end
    seg_end = (col + 1) >= seg_len;
    last = seg_end && seg_idx == SEG_IDX_LAST && (row_pair + 1) >= height / 2;
    e.addr = addr[ADDR_W-1:0];
    e.pix = b ^ SIGN_FLIP;
    e.last = last;
    pending_dests.push_back(e);
    if (last) begin
      seg_idx = '0;
      col = 0;
      row_pair = 0;
    end else if (seg_end) begin
      col = 0;
      if (seg_idx == SEG_IDX_LAST) row_pair++;
      seg_idx = seg_idx + 2'd1;
    end else begin
      col++;
    end
  endfunction

  function void check_result(logic [ADDR_W-1:0] addr, logic [PIX_W-1:0] pix, logic last);
    dest_word_t e;
    if (pending_dests.size() == 0) begin
      $display("%0t unexpected result: addr %0d pixel %0h last %0b", $time, addr, pix, last);
      errors++;
      return;
    end
    e = pending_dests.pop_front();
    bytes_checked++;
    if (e.addr !== addr) begin
      $display("%0t dest_addr mismatch: expected %0d actual %0d", $time, e.addr, addr);
      errors++;
    end
    if (e.pix !== pix) begin
      $display("%0t pixel mismatch: expected %0h actual %0h", $time, e.pix, pix);
      errors++;
    end
    if (e.last !== last) begin
      $display("%0t frame_last mismatch: expected %0b actual %0b", $time, e.last, last);
      errors++;
    end
    if (e.last) frames_done++;
  endfunction
endclass

module tb_line_interleaved_yuv_to_planar_yuv420_core;

  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_BYTES = 900;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              src_valid = 1'b0;
  logic              src_stall;
  logic [PIX_W-1:0]  src_byte = '0;
  logic              dst_valid;
  logic              dst_stall = 1'b0;
  logic [ADDR_W-1:0] dest_addr;
  logic [PIX_W-1:0]  pixel;
  logic              frame_last;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [CFG_W-1:0]  cfg_data = '0;

  bit                quiet = 1'b0;
  int                cycle_count = 0;
  i420_addr_tracker  board = new();

  line_interleaved_yuv_to_planar_yuv420_core uut (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_byte  (src_byte),
    .dst_valid (dst_valid),
    .dst_stall (dst_stall),
    .dest_addr (dest_addr),
    .pixel     (pixel),
    .frame_last(frame_last),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (dst_valid && !dst_stall) board.check_result(dest_addr, pixel, frame_last);
      if (src_valid && !src_stall) board.note_byte(src_byte);
      if (cfg_valid && cfg_ready) board.apply_write(cfg_index, cfg_data);
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        dst_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      dst_stall <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  task automatic send_byte(logic [PIX_W-1:0] b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      src_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    src_valid <= 1'b1;
    src_byte <= b;
    do @(posedge clk); while (src_stall);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    src_valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (board.pending_dests.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  initial begin
    int random_sent;
    int n;
    int r;
    int phases;
    int quiet_phases;
    random_sent = 0;
    phases = 0;
    quiet_phases = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_byte(8'h00);
    send_byte(8'h7f);
    send_byte(8'h80);
    send_byte(8'hff);
    send_byte(8'h55);
    send_byte(8'haa);
    drain();

    // refused values: frame position must carry on
    write_reg(CFG_LAYOUT, 13'd3);
    write_reg(CFG_LAYOUT, 13'd8191);
    write_reg(CFG_WIDTH, 13'd0);
    write_reg(CFG_WIDTH, 13'd8);
    write_reg(CFG_WIDTH, 13'd24);
    write_reg(CFG_WIDTH, 13'd4112);
    write_reg(CFG_HEIGHT, 13'd0);
    write_reg(CFG_HEIGHT, 13'd3);
    write_reg(CFG_HEIGHT, 13'd4098);
    write_reg(CFG_HEIGHT, 13'd8191);
    send_byte(8'h01);
    send_byte(8'hfe);
    drain();

    write_reg(CFG_WIDTH, 13'd4096);
    write_reg(CFG_HEIGHT, 13'd4096);
    write_reg(CFG_LAYOUT, CFG_W'(LAYOUT_YUVY));
    write_reg(CFG_SWAP, 13'd1);
    repeat (4) send_byte(PIX_W'($urandom_range(0, 255)));
    drain();

    write_reg(CFG_WIDTH, 13'd16);
    write_reg(CFG_HEIGHT, 13'd2);
    write_reg(CFG_LAYOUT, CFG_W'(LAYOUT_YYUV));
    write_reg(CFG_SWAP, 13'd0);
    repeat (10) send_byte(PIX_W'($urandom_range(0, 255)));
    drain();

    while (random_sent < RANDOM_BYTES) begin
      quiet = ($urandom_range(0, 3) == 0);
      phases++;
      if (quiet) quiet_phases++;
      if ($urandom_range(0, 99) < 60) begin
        r = $urandom_range(0, 9);
        if (r < 8) write_reg(CFG_LAYOUT, CFG_W'($urandom_range(0, 2)));
        else if (r == 8) write_reg(CFG_LAYOUT, 13'd3);
        else write_reg(CFG_LAYOUT, CFG_W'($urandom_range(0, 8191)));
      end
      if ($urandom_range(0, 99) < 60) write_reg(CFG_SWAP, CFG_W'($urandom_range(0, 8191)));
      if ($urandom_range(0, 99) < 60) begin
        r = $urandom_range(0, 19);
        if (r < 14) write_reg(CFG_WIDTH, CFG_W'(16 * $urandom_range(1, 4)));
        else if (r < 17) write_reg(CFG_WIDTH, CFG_W'(16 * $urandom_range(5, 16)));
        else if (r == 17) write_reg(CFG_WIDTH, 13'd4096);
        else write_reg(CFG_WIDTH, CFG_W'($urandom_range(0, 8191)));
      end
      if ($urandom_range(0, 99) < 60) begin
        r = $urandom_range(0, 19);
        if (r < 14) write_reg(CFG_HEIGHT, CFG_W'(2 * $urandom_range(1, 4)));
        else if (r < 16) write_reg(CFG_HEIGHT, CFG_W'(2 * $urandom_range(5, 32)));
        else if (r == 16) write_reg(CFG_HEIGHT, 13'd4096);
        else write_reg(CFG_HEIGHT, CFG_W'($urandom_range(0, 8191)));
      end
      n = (board.width > 256) ? $urandom_range(8, 40) : $urandom_range(30, 120);
      repeat (n) send_byte(PIX_W'($urandom_range(0, 255)));
      random_sent += n;
      drain();
    end

    if (board.pending_dests.size() != 0) begin
      $display("%0t %0d results never arrived", $time, board.pending_dests.size());
      board.errors++;
    end
    $display("checked %0d bytes, %0d complete frames, %0d register writes taken, %0d refused",
             board.bytes_checked, board.frames_done, board.writes_taken, board.writes_refused);
    $display("random phases %0d, of which %0d without idling", phases, quiet_phases);
    if (board.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/core/liyuv_pkg.sv
rtl/core/line_interleaved_yuv_to_planar_yuv420_core.sv
tb/tb_line_interleaved_yuv_to_planar_yuv420_core.sv
